// ----- src/mm3_pkg.sv -----
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared constants, sequencer step codes, control structs and rotate helpers
// for the MurmurHash3 x86_32 stream core.
// ----------------------------------------------------------------------------
`default_nettype none

package mm3_pkg;

	// Field widths of the stream beats.
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 3;

	// Block and finalizer constants.
	localparam logic [WORD_W-1:0] MM_C1 = 32'hcc9e2d51;
	localparam logic [WORD_W-1:0] MM_C2 = 32'h1b873593;
	localparam logic [WORD_W-1:0] MM_F1 = 32'h85ebca6b;
	localparam logic [WORD_W-1:0] MM_F2 = 32'hc2b2ae35;
	localparam logic [WORD_W-1:0] MM_N  = 32'he6546b64;
	localparam int MM_R1 = 15;
	localparam int MM_R2 = 13;
	localparam int MM_S1 = 16;
	localparam int MM_S2 = 13;

	// Bytes in a full block.
	localparam logic [COUNT_W-1:0] FULL_BYTES = 3'd4;

	// Sequencer step codes.
	localparam int STATE_W = 3;
	localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
	localparam logic [STATE_W-1:0] ST_K2   = 3'd1;
	localparam logic [STATE_W-1:0] ST_MIX  = 3'd2;
	localparam logic [STATE_W-1:0] ST_FIN0 = 3'd3;
	localparam logic [STATE_W-1:0] ST_FIN1 = 3'd4;
	localparam logic [STATE_W-1:0] ST_FIN2 = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture a beat and do the first premix multiply
		logic premix2;  // rotate and second premix multiply
		logic mix;      // fold the premixed word into the running hash
		logic fin0;     // xor in length, first avalanche multiply
		logic fin1;     // second avalanche multiply
		logic fin2;     // last avalanche xor, load result, clear state
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;     // the word in flight ends the string
	} status_t;

	function automatic logic [WORD_W-1:0] rotl_r1(input logic [WORD_W-1:0] x);
		return {x[WORD_W-1-MM_R1:0], x[WORD_W-1:WORD_W-MM_R1]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl_r2(input logic [WORD_W-1:0] x);
		return {x[WORD_W-1-MM_R2:0], x[WORD_W-1:WORD_W-MM_R2]};
	endfunction

endpackage

`default_nettype wire

// ----- src/mm3_if.sv -----
// ----------------------------------------------------------------------------
// mm3 stream interfaces
// Valid/ready channels for the input words and the finished hashes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm3_in_if;
	logic                          valid;
	logic                          ready;
	logic [mm3_pkg::WORD_W-1:0]    data_word;
	logic [mm3_pkg::COUNT_W-1:0]   byte_count;
	logic                          last;

	modport source (output valid, output data_word, output byte_count, output last,
		input ready);
	modport sink (input valid, input data_word, input byte_count, input last,
		output ready);
endinterface

interface mm3_out_if;
	logic                          valid;
	logic                          ready;
	logic [mm3_pkg::WORD_W-1:0]    hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// ----- src/murmur3_32_hash_stream_core.sv -----
// ----------------------------------------------------------------------------
// murmur3_32_hash_stream_core
// MurmurHash3 x86_32 (seed zero) of a byte string streamed as 32-bit words.
// ----------------------------------------------------------------------------
// The words channel carries little-endian string words; last marks the final
// beat, whose byte_count (0 to 4, larger values count as 4) gives its valid
// bytes. The hashes channel returns one hash_value per string.
// Each word beat runs in order through capture with the first premix multiply,
// the second premix multiply, and the block mix. A last beat adds three finalizer
// steps; the last one loads the hash once the hashes channel has room. The one
// shared sequencer, with at most one 32x32 multiply per step, orders these steps.
// The next string may start while a finished hash still waits on the hashes
// channel; if the receiver stalls, the core holds before loading a second
// hash until the first one has been taken.
// Reset clears the running hash, the byte length and the output valid; the
// core is ready for a word in the first cycle after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur3_32_hash_stream_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mm3_in_if.sink     words,
	mm3_out_if.source  hashes
);
	import mm3_pkg::*;

	cmd_t    cmd;
	status_t status;

	mm3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (words.valid),
		.in_ready  (words.ready),
		.out_valid (hashes.valid),
		.out_ready (hashes.ready),
		.cmd       (cmd),
		.status    (status)
	);

	mm3_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.data_word  (words.data_word),
		.byte_count (words.byte_count),
		.last       (words.last),
		.hash_value (hashes.hash_value)
	);

endmodule

`default_nettype wire

// ----- src/mm3_datapath.sv -----
// ----------------------------------------------------------------------------
// mm3_datapath
// Premix, block mix and avalanche registers, with at most one multiply per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mm3_pkg::cmd_t                 cmd,
	output mm3_pkg::status_t                   status,
	input  wire logic [mm3_pkg::WORD_W-1:0]    data_word,
	input  wire logic [mm3_pkg::COUNT_W-1:0]   byte_count,
	input  wire logic                          last,
	output logic      [mm3_pkg::WORD_W-1:0]    hash_value
);
	import mm3_pkg::*;

	logic [WORD_W-1:0]  k_q;
	logic [WORD_W-1:0]  h_q;
	logic [WORD_W-1:0]  len_q;
	logic [WORD_W-1:0]  t_q;
	logic [WORD_W-1:0]  hash_q;
	logic               last_q;
	logic               full_q;

	logic [COUNT_W-1:0] count_sat;
	logic [WORD_W-1:0]  mask;
	logic [WORD_W-1:0]  k_in;
	logic [WORD_W-1:0]  k1_prod;
	logic [WORD_W-1:0]  k2_prod;
	logic [WORD_W-1:0]  h_x;
	logic [WORD_W-1:0]  h_rot;
	logic [WORD_W-1:0]  h_mix;
	logic [WORD_W-1:0]  f_x;
	logic [WORD_W-1:0]  f0_prod;
	logic [WORD_W-1:0]  f1_x;
	logic [WORD_W-1:0]  f1_prod;
	logic [WORD_W-1:0]  len_inc;

	// Byte count saturates at a full block; words that are not last are full.
	always_comb begin
		count_sat = (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;
		if (!last) begin
			count_sat = FULL_BYTES;
		end
		case (count_sat)
			3'd0:    mask = 32'h0000_0000;
			3'd1:    mask = 32'h0000_00ff;
			3'd2:    mask = 32'h0000_ffff;
			3'd3:    mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
		k_in    = data_word & mask;
		len_inc = len_q + {{(WORD_W-COUNT_W){1'b0}}, count_sat};
	end

	// Premix multiplies, each followed by a register.
	assign k1_prod = k_in * MM_C1;
	assign k2_prod = rotl_r1(k_q) * MM_C2;

	// Block mix: rotate, then times five plus the offset by shift and add.
	assign h_x   = h_q ^ k_q;
	assign h_rot = rotl_r2(h_x);
	assign h_mix = {h_rot[WORD_W-3:0], 2'b00} + h_rot + MM_N;

	// Avalanche steps.
	assign f_x     = h_q ^ len_q;
	assign f0_prod = (f_x ^ (f_x >> MM_S1)) * MM_F1;
	assign f1_x    = t_q ^ (t_q >> MM_S2);
	assign f1_prod = f1_x * MM_F2;

	// Control-bearing state: running hash, length and beat flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= '0;
			len_q  <= '0;
			last_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				len_q  <= len_inc;
				last_q <= last;
				full_q <= (count_sat == FULL_BYTES);
			end
			if (cmd.mix) begin
				h_q <= full_q ? h_mix : h_x;
			end
			if (cmd.fin2) begin
				h_q   <= '0;
				len_q <= '0;
			end
		end
	end

	// Work and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q <= k1_prod;
		end
		if (cmd.premix2) begin
			k_q <= k2_prod;
		end
		if (cmd.fin0) begin
			t_q <= f0_prod;
		end
		if (cmd.fin1) begin
			t_q <= f1_prod;
		end
		if (cmd.fin2) begin
			hash_q <= t_q ^ (t_q >> MM_S1);
		end
	end

	assign status.last = last_q;
	assign hash_value  = hash_q;

endmodule

`default_nettype wire

// ----- src/mm3_ctrl.sv -----
// ----------------------------------------------------------------------------
// mm3_ctrl
// Sequencer for the hash datapath and the output beat valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mm3_pkg::cmd_t           cmd,
	input  wire mm3_pkg::status_t   status
);
	import mm3_pkg::*;

	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] state_nxt;
	logic               out_valid_q;
	logic               slot_free;
	logic               accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Next state and datapath commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load  = 1'b1;
					state_nxt = ST_K2;
				end
			end
			ST_K2: begin
				cmd.premix2 = 1'b1;
				state_nxt   = ST_MIX;
			end
			ST_MIX: begin
				cmd.mix   = 1'b1;
				state_nxt = status.last ? ST_FIN0 : ST_IDLE;
			end
			ST_FIN0: begin
				cmd.fin0  = 1'b1;
				state_nxt = ST_FIN1;
			end
			ST_FIN1: begin
				cmd.fin1  = 1'b1;
				state_nxt = ST_FIN2;
			end
			ST_FIN2: begin
				if (slot_free) begin
					cmd.fin2  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.fin2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MurmurHash3 x86_32 stream core.
// ----------------------------------------------------------------------------
// Strings are streamed into the words channel as little-endian beats. A
// local predictor mirrors the running hash and byte length and queues the
// expected hash for each string. A receiver process pulls hashes with
// random stalls and compares each one against the oldest queued hash. The
// tests cover the byte count corner cases, long random strings, stretches
// with no idling, and a long receiver stall that backs up the core.
// ----------------------------------------------------------------------------

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mm3_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned TAIL_CYCLES = 40;
	localparam int unsigned RANDOM_WORDS = 1000;
	localparam int unsigned NO_IDLE_WORDS = 120;

	logic clk;
	logic arst_n;

	mm3_in_if  words_if ();
	mm3_out_if hashes_if ();

	murmur3_32_hash_stream_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.words  (words_if),
		.hashes (hashes_if)
	);

	// Predictor state for the string in progress.
	logic [WORD_W-1:0] str_hash;
	logic [WORD_W-1:0] str_bytes;
	logic [WORD_W-1:0] pending_hashes[$];

	int unsigned err_count;
	int unsigned words_sent;
	int unsigned cycle_count;
	bit          tx_idle;
	bit          rx_idle;
	bit          rx_hold;
	int unsigned rx_wait;
	event        hold_go;

	// Free-running clock, 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog on the total run length.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Hash arithmetic
	// ------------------------------------------------------------------

	function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] x,
		input int unsigned r);
		return (x << r) | (x >> (WORD_W - r));
	endfunction

	function automatic logic [WORD_W-1:0] scramble_key(input logic [WORD_W-1:0] k);
		logic [WORD_W-1:0] t;
		t = k * MM_C1;
		t = rotate_left(t, 15);
		return t * MM_C2;
	endfunction

	function automatic logic [WORD_W-1:0] fold_block(input logic [WORD_W-1:0] h,
		input logic [WORD_W-1:0] k);
		logic [WORD_W-1:0] t;
		t = h ^ scramble_key(k);
		t = rotate_left(t, 13);
		return t * 32'd5 + MM_N;
	endfunction

	function automatic logic [WORD_W-1:0] final_mix(input logic [WORD_W-1:0] h);
		logic [WORD_W-1:0] t;
		t = h ^ (h >> 16);
		t = t * MM_F1;
		t = t ^ (t >> 13);
		t = t * MM_F2;
		return t ^ (t >> 16);
	endfunction

	// Advance the predictor by one accepted beat; a last beat queues a hash.
	task automatic track_word(input logic [WORD_W-1:0] data, input logic [COUNT_W-1:0] cnt,
		input logic fin);
		logic [WORD_W-1:0] h;
		logic [WORD_W-1:0] mask;
		logic [COUNT_W-1:0] n;
		if (!fin) begin
			str_hash = fold_block(str_hash, data);
			str_bytes = str_bytes + 32'd4;
		end else begin
			n = (cnt > FULL_BYTES) ? FULL_BYTES : cnt;
			h = str_hash;
			if (n == FULL_BYTES) begin
				h = fold_block(h, data);
			end else if (n != 0) begin
				mask = (32'h1 << (8 * n)) - 32'h1;
				h = h ^ scramble_key(data & mask);
			end
			h = h ^ (str_bytes + WORD_W'(n));
			pending_hashes.insert(pending_hashes.size(), final_mix(h));
			str_hash = '0;
			str_bytes = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_hash(input logic [WORD_W-1:0] got);
		logic [WORD_W-1:0] want;
		if (pending_hashes.size() == 0) begin
			report($sformatf("hash %08h arrived with no string pending", got));
		end else begin
			want = pending_hashes.pop_front();
			if (got !== want)
				report($sformatf("hash_value got %08h, want %08h", got, want));
		end
	endtask

	// Idle length: mostly none or short, occasionally long.
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Receiver: takes hashes, checks them, stalls at random or on a hold.
	initial begin
		hashes_if.ready <= 1'b0;
		rx_wait = 0;
		forever begin
			@(posedge clk);
			if (hashes_if.valid && hashes_if.ready)
				check_hash(hashes_if.hash_value);
			if (rx_hold) begin
				hashes_if.ready <= 1'b0;
			end else if (rx_wait != 0) begin
				hashes_if.ready <= 1'b0;
				rx_wait--;
			end else begin
				hashes_if.ready <= 1'b1;
				if (rx_idle)
					rx_wait = idle_gap();
			end
		end
	end

	// Long receiver hold-off, counted here in cycles once triggered.
	initial begin
		rx_hold <= 1'b0;
		forever begin
			@(hold_go);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offer one beat, wait for it to be taken, then maybe leave a gap.
	task automatic send_word(input logic [WORD_W-1:0] data, input logic [COUNT_W-1:0] cnt,
		input logic fin);
		int unsigned gap;
		words_if.valid      <= 1'b1;
		words_if.data_word  <= data;
		words_if.byte_count <= cnt;
		words_if.last       <= fin;
		@(posedge clk);
		while (!words_if.ready)
			@(posedge clk);
		track_word(data, cnt, fin);
		words_sent++;
		gap = tx_idle ? idle_gap() : 0;
		if (gap != 0) begin
			words_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [WORD_W-1:0] random_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		else
			return $urandom;
	endfunction

	// Mostly valid byte counts on the last beat, some above four.
	function automatic logic [COUNT_W-1:0] random_tail();
		if ($urandom_range(0, 9) < 8)
			return COUNT_W'($urandom_range(0, 4));
		else
			return COUNT_W'($urandom_range(5, 7));
	endfunction

	task automatic send_string(input int unsigned full_words, input logic [COUNT_W-1:0] tail);
		for (int unsigned i = 0; i < full_words; i++)
			send_word(random_word(), COUNT_W'($urandom_range(0, 7)), 1'b0);
		send_word(random_word(), tail, 1'b1);
	endtask

	// Short strings dominate; a few run to tens of words.
	task automatic send_random_string();
		int unsigned r;
		int unsigned len;
		r = $urandom_range(0, 99);
		if (r < 70)
			len = $urandom_range(0, 6);
		else if (r < 95)
			len = $urandom_range(7, 20);
		else
			len = $urandom_range(21, 64);
		send_string(len, random_tail());
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Byte count corners, empty strings, field extremes.
	task automatic test_directed();
		tx_idle = 1'b1;
		rx_idle <= 1'b1;
		send_word(32'h00000000, 3'd0, 1'b1);
		send_word(32'hffffffff, 3'd0, 1'b1);
		send_word(32'h000000ab, 3'd1, 1'b1);
		send_word(32'hffffffff, 3'd1, 1'b1);
		send_word(32'hffff1234, 3'd2, 1'b1);
		send_word(32'hdeadbeef, 3'd3, 1'b1);
		send_word(32'hffffffff, 3'd4, 1'b1);
		send_word(32'h00000000, 3'd4, 1'b1);
		send_word(32'h89abcdef, 3'd5, 1'b1);
		send_word(32'h89abcdef, 3'd6, 1'b1);
		send_word(32'h89abcdef, 3'd7, 1'b1);
		// Byte count on a middle beat is ignored.
		send_word(32'h01234567, 3'd0, 1'b0);
		send_word(32'h01234567, 3'd7, 1'b0);
		send_word(32'h00000000, 3'd0, 1'b1);
		send_word(32'hffffffff, 3'd2, 1'b0);
		send_word(32'h00000000, 3'd0, 1'b0);
		send_word(32'h80000001, 3'd5, 1'b0);
		send_word(32'h7fffff00, 3'd3, 1'b1);
		send_word(32'hcafef00d, 3'd1, 1'b0);
		send_word(32'hffffffff, 3'd4, 1'b1);
	endtask

	// Random strings with idling on both sides.
	task automatic test_random_strings();
		int unsigned stop_at;
		tx_idle = 1'b1;
		rx_idle <= 1'b1;
		stop_at = words_sent + RANDOM_WORDS;
		while (words_sent < stop_at)
			send_random_string();
	endtask

	// Back-to-back beats with an always-ready receiver.
	task automatic test_no_idle();
		int unsigned stop_at;
		tx_idle = 1'b0;
		rx_idle <= 1'b0;
		stop_at = words_sent + NO_IDLE_WORDS;
		while (words_sent < stop_at)
			send_random_string();
	endtask

	// Receiver holds off while short strings keep coming, so the core backs up.
	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_idle <= 1'b1;
		-> hold_go;
		for (int i = 0; i < 30; i++)
			send_string($urandom_range(0, 1), random_tail());
		tx_idle = 1'b1;
		for (int i = 0; i < 10; i++)
			send_string($urandom_range(0, 2), random_tail());
	endtask

	// Stop offering, let every hash come back, then settle.
	task automatic drain();
		words_if.valid <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		err_count = 0;
		words_sent = 0;
		str_hash = '0;
		str_bytes = '0;
		tx_idle = 1'b0;
		rx_idle <= 1'b0;
		arst_n <= 1'b0;
		words_if.valid      <= 1'b0;
		words_if.data_word  <= '0;
		words_if.byte_count <= '0;
		words_if.last       <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_strings();
		test_no_idle();
		test_backpressure();
		drain();

		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
